### rtl/bqe_pkg.sv
// bqe_pkg: shared constants, opcode/kind/error codes and request/result types
// for the bitmap query bytecode executor. Depends on nothing.
`timescale 1ns / 1ps

package bqe_pkg;

    localparam int VALUE_STACK_DEPTH = 16;
    localparam int CALL_STACK_DEPTH  = 8;
    localparam int IP_WIDTH          = 16;
    localparam int GROUPS            = 64;

    localparam int VSP_W  = $clog2(VALUE_STACK_DEPTH + 1);
    localparam int VIDX_W = $clog2(VALUE_STACK_DEPTH);
    localparam int RSP_W  = $clog2(CALL_STACK_DEPTH + 1);
    localparam int RIDX_W = (CALL_STACK_DEPTH > 1) ? $clog2(CALL_STACK_DEPTH) : 1;
    localparam int GRP_W  = $clog2(GROUPS);

    localparam logic [4:0] OP_ANDROW   = 5'd0;
    localparam logic [4:0] OP_LOADROW  = 5'd1;
    localparam logic [4:0] OP_SHL      = 5'd2;
    localparam logic [4:0] OP_SHR      = 5'd3;
    localparam logic [4:0] OP_INC      = 5'd4;
    localparam logic [4:0] OP_PUSH     = 5'd5;
    localparam logic [4:0] OP_POP      = 5'd6;
    localparam logic [4:0] OP_ANDSTK   = 5'd7;
    localparam logic [4:0] OP_NOT      = 5'd8;
    localparam logic [4:0] OP_ORSTK    = 5'd9;
    localparam logic [4:0] OP_UPDFLAGS = 5'd10;
    localparam logic [4:0] OP_REPORT   = 5'd11;
    localparam logic [4:0] OP_CALL     = 5'd12;
    localparam logic [4:0] OP_JMP      = 5'd13;
    localparam logic [4:0] OP_JNZ      = 5'd14;
    localparam logic [4:0] OP_JZ       = 5'd15;
    localparam logic [4:0] OP_RET      = 5'd16;
    localparam logic [4:0] OP_END      = 5'd17;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_GROUP = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OPCODE    = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_CALL      = 3'd4;
    localparam logic [2:0] ERR_RANGE     = 3'd5;

    typedef struct packed {
        logic                start;
        logic [23:0]         iteration;
        logic [4:0]          opcode;
        logic [5:0]          shamt;
        logic [63:0]         word;
        logic [IP_WIDTH-1:0] target;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] next_ip;
        logic [31:0] offset;
        logic [63:0] acc;
        logic [31:0] gidx;
        logic [63:0] gbits;
        logic [2:0]  err;
        logic        last;
    } result_t;

endpackage

### rtl/bitmap_query_bytecode_executor_unit.sv
// bitmap_query_bytecode_executor_unit: top level, front queue plus execution back end.
// Depends on bqe_pkg, bqe_front, bqe_back (and bqe_ram through bqe_back).
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   config   | cfg_wr_en            | cfg_wr_data (initial_rank)
//   request  | in_valid / in_stall  | operation iteration opcode shift_amount
//            |                      | invert row_word jump_target
//   result   | out_valid/out_stall  | kind next_ip current_offset acc_value
//            |                      | group_index group_bits error_code last
//
// most instructions execute from the head of the two-entry queue once the output is free
// report with a live accumulator does a group store read, then a write
// end scans one group per cycle; each non-empty group is read from the group store and
// then emitted once the output is free, bounded by the single group store read port
// reset clears all control state and the group valid map; no clearing pass
// a stalled result holds the output register; the queue keeps taking requests until full
`timescale 1ns / 1ps

module bitmap_query_bytecode_executor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [23:0] iteration,
    input  logic [4:0]  opcode,
    input  logic [5:0]  shift_amount,
    input  logic        invert,
    input  logic [63:0] row_word,
    input  logic [15:0] jump_target,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] next_ip,
    output logic [31:0] current_offset,
    output logic [63:0] acc_value,
    output logic [31:0] group_index,
    output logic [63:0] group_bits,
    output logic [2:0]  error_code,
    output logic        last
);

    logic             q_valid;
    logic             q_pop;
    bqe_pkg::item_t   q_item;
    bqe_pkg::result_t res;

    bqe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .iteration    (iteration),
        .opcode       (opcode),
        .shift_amount (shift_amount),
        .invert       (invert),
        .row_word     (row_word),
        .jump_target  (jump_target),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    bqe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_res     (res)
    );

    assign kind           = res.kind;
    assign next_ip        = res.next_ip;
    assign current_offset = res.offset;
    assign acc_value      = res.acc;
    assign group_index    = res.gidx;
    assign group_bits     = res.gbits;
    assign error_code     = res.err;
    assign last           = res.last;

endmodule

### rtl/bqe_ram.sv
// bqe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bqe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bqe_front.sv
// bqe_front: accepts requests, applies row inversion, casts the jump target,
// and holds them in a two-entry queue for the back end. Uses bqe_pkg.
`timescale 1ns / 1ps

module bqe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [23:0]        iteration,
    input  logic [4:0]         opcode,
    input  logic [5:0]         shift_amount,
    input  logic               invert,
    input  logic [63:0]        row_word,
    input  logic [15:0]        jump_target,
    output logic               q_valid,
    output bqe_pkg::item_t     q_item,
    input  logic               q_pop
);

    bqe_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    bqe_pkg::item_t new_item;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.start     = !operation;
        new_item.iteration = iteration;
        new_item.opcode    = opcode;
        new_item.shamt     = shift_amount;
        new_item.word      = invert ? ~row_word : row_word;
        new_item.target    = bqe_pkg::IP_WIDTH'(jump_target);
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### rtl/bqe_back.sv
// bqe_back: executes queued requests against accumulator, offset, stacks and
// the group store; drains groups on end. Uses bqe_pkg and bqe_ram.
`timescale 1ns / 1ps

module bqe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                q_valid,
    input  bqe_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output bqe_pkg::result_t    out_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RPT  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int IPW = bqe_pkg::IP_WIDTH;
    localparam int GW  = bqe_pkg::GRP_W;

    logic [1:0]                 state_reg, state_next;
    logic [2:0]                 rank_reg;
    logic [63:0]                acc_reg, acc_next;
    logic [31:0]                offset_reg, offset_next;
    logic [31:0]                base_reg, base_next;
    logic [IPW-1:0]             ip_reg, ip_next;
    logic [bqe_pkg::VSP_W-1:0]  vsp_reg, vsp_next;
    logic [bqe_pkg::RSP_W-1:0]  rsp_reg, rsp_next;
    logic [bqe_pkg::GROUPS-1:0] map_reg, map_next;
    logic [GW-1:0]              grp_reg, grp_next;
    logic                       out_valid_reg, out_valid_next;
    bqe_pkg::result_t           out_reg, out_next;

    logic [63:0] vstk [bqe_pkg::VALUE_STACK_DEPTH];
    logic [IPW-1:0] rstk [bqe_pkg::CALL_STACK_DEPTH];

    logic                        vstk_we, rstk_we;
    logic [bqe_pkg::VIDX_W-1:0]  vtop_idx, vpush_idx;
    logic [bqe_pkg::RIDX_W-1:0]  rtop_idx, rpush_idx;
    logic [63:0]                 vtop;
    logic [IPW-1:0]              rtop, nip;
    logic [31:0]                 grp_dist;

    logic           ram_wr_en, ram_rd_en;
    logic [GW-1:0]  ram_wr_addr, ram_rd_addr;
    logic [63:0]    ram_wr_data, ram_rd_data;

    logic                       out_free, emit, emit_last;
    logic [1:0]                 emit_kind;
    logic [2:0]                 emit_err;
    logic [31:0]                emit_gidx;
    logic [63:0]                emit_gbits;
    logic [bqe_pkg::GROUPS-1:0] map_clr;

    bqe_ram #(
        .WIDTH (64),
        .DEPTH (bqe_pkg::GROUPS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    assign vtop_idx  = bqe_pkg::VIDX_W'(vsp_reg - 1'b1);
    assign vpush_idx = bqe_pkg::VIDX_W'(vsp_reg);
    assign rtop_idx  = bqe_pkg::RIDX_W'(rsp_reg - 1'b1);
    assign rpush_idx = bqe_pkg::RIDX_W'(rsp_reg);
    assign vtop      = vstk[vtop_idx];
    assign rtop      = rstk[rtop_idx];
    assign nip       = ip_reg + 1'b1;
    assign grp_dist  = offset_reg - base_reg;
    assign map_clr   = map_reg & ~(bqe_pkg::GROUPS'(1) << grp_reg);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        offset_next    = offset_reg;
        base_next      = base_reg;
        ip_next        = ip_reg;
        vsp_next       = vsp_reg;
        rsp_next       = rsp_reg;
        map_next       = map_reg;
        grp_next       = grp_reg;
        q_pop          = 1'b0;
        vstk_we        = 1'b0;
        rstk_we        = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = grp_reg;
        ram_wr_data    = (map_reg[grp_reg] ? ram_rd_data : 64'd0) | acc_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = grp_reg;
        emit           = 1'b0;
        emit_kind      = bqe_pkg::KIND_DONE;
        emit_err       = bqe_pkg::ERR_NONE;
        emit_gidx      = 32'd0;
        emit_gbits     = 64'd0;
        emit_last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    if (q_item.start)
                    begin
                        base_next   = {8'd0, q_item.iteration} << rank_reg;
                        offset_next = {8'd0, q_item.iteration};
                        acc_next    = 64'd0;
                        ip_next     = '0;
                        vsp_next    = '0;
                        rsp_next    = '0;
                    end
                    else
                    begin
                        unique case (q_item.opcode)
                            bqe_pkg::OP_ANDROW:
                            begin
                                acc_next = acc_reg & q_item.word;
                                ip_next  = nip;
                            end
                            bqe_pkg::OP_LOADROW:
                            begin
                                acc_next = q_item.word;
                                ip_next  = nip;
                            end
                            bqe_pkg::OP_SHL:
                            begin
                                offset_next = offset_reg << q_item.shamt;
                                ip_next     = nip;
                            end
                            bqe_pkg::OP_SHR:
                            begin
                                offset_next = offset_reg >> q_item.shamt;
                                ip_next     = nip;
                            end
                            bqe_pkg::OP_INC:
                            begin
                                offset_next = offset_reg + 32'd1;
                                ip_next     = nip;
                            end
                            bqe_pkg::OP_PUSH:
                            begin
                                if (vsp_reg == bqe_pkg::VSP_W'(bqe_pkg::VALUE_STACK_DEPTH))
                                begin
                                    emit_kind = bqe_pkg::KIND_ERROR;
                                    emit_err  = bqe_pkg::ERR_OVERFLOW;
                                end
                                else
                                begin
                                    vstk_we  = 1'b1;
                                    vsp_next = vsp_reg + 1'b1;
                                    ip_next  = nip;
                                end
                            end
                            bqe_pkg::OP_POP, bqe_pkg::OP_ANDSTK, bqe_pkg::OP_ORSTK,
                            bqe_pkg::OP_UPDFLAGS:
                            begin
                                if (vsp_reg == '0)
                                begin
                                    emit_kind = bqe_pkg::KIND_ERROR;
                                    emit_err  = bqe_pkg::ERR_UNDERFLOW;
                                end
                                else
                                begin
                                    ip_next = nip;
                                    if (q_item.opcode != bqe_pkg::OP_UPDFLAGS)
                                    begin
                                        vsp_next = vsp_reg - 1'b1;
                                    end
                                    if (q_item.opcode == bqe_pkg::OP_POP)
                                    begin
                                        acc_next = vtop;
                                    end
                                    else if (q_item.opcode == bqe_pkg::OP_ANDSTK)
                                    begin
                                        acc_next = acc_reg & vtop;
                                    end
                                    else if (q_item.opcode == bqe_pkg::OP_ORSTK)
                                    begin
                                        acc_next = acc_reg | vtop;
                                    end
                                end
                            end
                            bqe_pkg::OP_NOT:
                            begin
                                acc_next = ~acc_reg;
                                ip_next  = nip;
                            end
                            bqe_pkg::OP_REPORT:
                            begin
                                if (acc_reg == 64'd0)
                                begin
                                    ip_next = nip;
                                end
                                else if (grp_dist >= 32'(bqe_pkg::GROUPS))
                                begin
                                    emit_kind = bqe_pkg::KIND_ERROR;
                                    emit_err  = bqe_pkg::ERR_RANGE;
                                end
                                else
                                begin
                                    emit        = 1'b0;
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = GW'(grp_dist);
                                    grp_next    = GW'(grp_dist);
                                    state_next  = S_RPT;
                                end
                            end
                            bqe_pkg::OP_CALL:
                            begin
                                if (rsp_reg == bqe_pkg::RSP_W'(bqe_pkg::CALL_STACK_DEPTH))
                                begin
                                    emit_kind = bqe_pkg::KIND_ERROR;
                                    emit_err  = bqe_pkg::ERR_CALL;
                                end
                                else
                                begin
                                    rstk_we  = 1'b1;
                                    rsp_next = rsp_reg + 1'b1;
                                    ip_next  = q_item.target;
                                end
                            end
                            bqe_pkg::OP_JMP:
                            begin
                                ip_next = q_item.target;
                            end
                            bqe_pkg::OP_JNZ:
                            begin
                                ip_next = (acc_reg != 64'd0) ? q_item.target : nip;
                            end
                            bqe_pkg::OP_JZ:
                            begin
                                ip_next = (acc_reg == 64'd0) ? q_item.target : nip;
                            end
                            bqe_pkg::OP_RET:
                            begin
                                if (rsp_reg == '0)
                                begin
                                    emit_kind = bqe_pkg::KIND_ERROR;
                                    emit_err  = bqe_pkg::ERR_CALL;
                                end
                                else
                                begin
                                    rsp_next = rsp_reg - 1'b1;
                                    ip_next  = rtop;
                                end
                            end
                            bqe_pkg::OP_END:
                            begin
                                if (map_reg != '0)
                                begin
                                    emit       = 1'b0;
                                    grp_next   = '0;
                                    state_next = S_SCAN;
                                end
                            end
                            default:
                            begin
                                emit_kind = bqe_pkg::KIND_ERROR;
                                emit_err  = bqe_pkg::ERR_OPCODE;
                            end
                        endcase
                    end
                end
            end
            S_RPT:
            begin
                ram_wr_en          = 1'b1;
                map_next[grp_reg]  = 1'b1;
                ip_next            = nip;
                emit               = 1'b1;
                state_next         = S_IDLE;
            end
            S_SCAN:
            begin
                if (map_reg[grp_reg])
                begin
                    ram_rd_en  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = bqe_pkg::KIND_GROUP;
                    emit_gidx  = base_reg + 32'(grp_reg);
                    emit_gbits = ram_rd_data;
                    emit_last  = (map_clr == '0);
                    map_next   = map_clr;
                    grp_next   = grp_reg + 1'b1;
                    state_next = (map_clr == '0) ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_next = out_reg;
        if (emit)
        begin
            out_next.kind    = emit_kind;
            out_next.next_ip = 16'(ip_next);
            out_next.offset  = offset_next;
            out_next.acc     = acc_next;
            out_next.gidx    = emit_gidx;
            out_next.gbits   = emit_gbits;
            out_next.err     = emit_err;
            out_next.last    = emit_last;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rank_reg      <= 3'd0;
            acc_reg       <= 64'd0;
            offset_reg    <= 32'd0;
            base_reg      <= 32'd0;
            ip_reg        <= '0;
            vsp_reg       <= '0;
            rsp_reg       <= '0;
            map_reg       <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                rank_reg <= cfg_wr_data;
            end
            acc_reg       <= acc_next;
            offset_reg    <= offset_next;
            base_reg      <= base_next;
            ip_reg        <= ip_next;
            vsp_reg       <= vsp_next;
            rsp_reg       <= rsp_next;
            map_reg       <= map_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (vstk_we)
        begin
            vstk[vpush_idx] <= acc_reg;
        end
        if (rstk_we)
        begin
            rstk[rpush_idx] <= nip;
        end
    end

endmodule
